// ----- hdl/finc_pkg.sv -----
package finc_pkg;

   localparam int BUF_ID_W = 6;

   typedef enum logic [2:0] {
      REQ_GET    = 3'd0,
      REQ_PUSH   = 3'd1,
      REQ_SHIFT  = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_SWAP   = 3'd4,
      REQ_FIND   = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [31:0]        node_key;
      logic [31:0]        second_key;
      logic [15:0]        entry_len;
      logic [31:0]        begin_pos;
      logic [15:0]        tree_id;
      logic [31:0]        ref_index;
      logic signed [31:0] add_value;
      logic [31:0]        position;
   } req_item_type;

   typedef struct packed {
      logic                hit;
      logic [BUF_ID_W-1:0] buffer_id;
      logic                fill_needed;
      logic                evict_valid;
      logic [31:0]         evict_key;
      logic                found;
      logic [31:0]         found_key;
      logic [31:0]         found_start;
   } rsp_item_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] start;
      logic [15:0] tree;
      logic [15:0] len;
   } slot_type;

endpackage

// ----- hdl/front_insert_node_cache_tags_core.sv -----
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_item (req_item_type)
// rsp_      out        rsp_valid/rsp_stall  rsp_item (rsp_item_type)
//
// One item per cycle sustained while rsp_stall is low.
// The slot table compares and updates all entries in the cycle between the input
// register and the result register.
// Synchronous reset empties every slot and gives slot i buffer i.
// A held result stalls the input only once the input register is also occupied.
module front_insert_node_cache_tags_core #(
   parameter int ENTRIES      = 8,
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  finc_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output finc_pkg::rsp_item_type rsp_item
);
   import finc_pkg::*;

   req_item_type req_item_ff;
   logic         req_vld_ff, req_vld_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_vld_ff, rsp_vld_in;
   rsp_item_type rsp_item_in;
   logic         fire, accept;

   assign fire      = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && rsp_vld_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign req_vld_in = accept || (req_vld_ff && !fire);
   assign rsp_vld_in = fire || (rsp_vld_ff && rsp_stall);

   finc_slots #(
      .ENTRIES      (ENTRIES),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_slots (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_item_ff),
      .rsp   (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_item_ff <= req_item;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- hdl/finc_slots.sv -----
module finc_slots #(
   parameter int ENTRIES      = 8,
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  finc_pkg::req_item_type req,
   output finc_pkg::rsp_item_type rsp
);
   import finc_pkg::*;

   localparam int            IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [15:0]   LEN_MAX = 16'(BUFFER_BYTES);
   localparam logic [IW-1:0] LAST    = IW'(ENTRIES - 1);

   slot_type          slot_ff [ENTRIES];
   slot_type          slot_in [ENTRIES];
   logic [IW-1:0]     buf_ff  [ENTRIES];
   logic [IW-1:0]     buf_in  [ENTRIES];

   logic [ENTRIES-1:0] hit_vec, b_vec, fnd_vec, free_vec;
   logic [IW-1:0]      hit_idx, a_idx, b_idx, fnd_idx, free_idx, rm_idx;
   logic               hit_any, b_any, fnd_any, ins_en, rm_en;
   logic [15:0]        len_clip;
   slot_type           new_slot;

   function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
      logic [IW-1:0] idx;
      idx = '0;
      for (int n = ENTRIES - 1; n >= 0; n--) begin
         if (v[n]) idx = IW'(n);
      end
      return idx;
   endfunction

   function automatic logic [IW-1:0] last_set(input logic [ENTRIES-1:0] v);
      logic [IW-1:0] idx;
      idx = '0;
      for (int n = 0; n < ENTRIES; n++) begin
         if (v[n]) idx = IW'(n);
      end
      return idx;
   endfunction

   always_comb begin
      for (int n = 0; n < ENTRIES; n++) begin
         hit_vec[n]  = slot_ff[n].valid && (slot_ff[n].key == req.node_key);
         b_vec[n]    = slot_ff[n].valid && (slot_ff[n].key == req.second_key) &&
                       (slot_ff[n].key != req.node_key);
         fnd_vec[n]  = slot_ff[n].valid && (slot_ff[n].tree == req.tree_id) &&
                       (req.position >= slot_ff[n].start) &&
                       ({1'b0, req.position} <
                        ({1'b0, slot_ff[n].start} + 33'(slot_ff[n].len)));
         free_vec[n] = !slot_ff[n].valid;
      end
      hit_any  = |hit_vec;
      b_any    = |b_vec;
      fnd_any  = |fnd_vec;
      hit_idx  = first_set(hit_vec);
      a_idx    = last_set(hit_vec);
      b_idx    = last_set(b_vec);
      fnd_idx  = first_set(fnd_vec);
      free_idx = (|free_vec) ? first_set(free_vec) : LAST;
      len_clip = (req.entry_len > LEN_MAX) ? LEN_MAX : req.entry_len;

      new_slot.valid = 1'b1;
      new_slot.key   = req.node_key;
      new_slot.start = req.begin_pos;
      new_slot.tree  = req.tree_id;
      new_slot.len   = len_clip;
   end

   always_comb begin
      slot_in = slot_ff;
      buf_in  = buf_ff;
      rsp             = '0;
      rsp.found_start = '1;
      ins_en = 1'b0;
      rm_en  = 1'b0;
      rm_idx = hit_idx;

      case (req_code_type'(req.req_type))
         REQ_GET: begin
            if (hit_any) begin
               rsp.hit       = 1'b1;
               rsp.buffer_id = BUF_ID_W'(buf_ff[hit_idx]);
            end else begin
               rsp.fill_needed = 1'b1;
               ins_en          = 1'b1;
            end
         end
         REQ_PUSH: begin
            ins_en = 1'b1;
         end
         REQ_SHIFT: begin
            for (int n = 0; n < ENTRIES; n++) begin
               if (slot_ff[n].valid && (slot_ff[n].tree == req.tree_id) &&
                   (slot_ff[n].start > req.ref_index)) begin
                  slot_in[n].start = slot_ff[n].start + $unsigned(req.add_value);
               end
            end
         end
         REQ_DELETE: begin
            rm_en = hit_any;
         end
         REQ_SWAP: begin
            if (hit_any && b_any) begin
               slot_in[a_idx].start = slot_ff[b_idx].start;
               slot_in[a_idx].tree  = slot_ff[b_idx].tree;
               buf_in[a_idx]        = buf_ff[b_idx];
               slot_in[b_idx].start = slot_ff[a_idx].start;
               slot_in[b_idx].tree  = slot_ff[a_idx].tree;
               buf_in[b_idx]        = buf_ff[a_idx];
            end else if (b_any) begin
               slot_in[b_idx].key   = req.node_key;
               slot_in[b_idx].start = req.begin_pos;
               slot_in[b_idx].tree  = req.tree_id;
               slot_in[b_idx].len   = len_clip;
            end else if (hit_any) begin
               rm_en  = 1'b1;
               rm_idx = a_idx;
            end
         end
         REQ_FIND: begin
            if (fnd_any) begin
               rsp.found       = 1'b1;
               rsp.found_key   = slot_ff[fnd_idx].key;
               rsp.found_start = slot_ff[fnd_idx].start;
            end
         end
         default: begin
         end
      endcase

      if (ins_en) begin
         rsp.evict_valid = slot_ff[free_idx].valid;
         rsp.evict_key   = slot_ff[free_idx].valid ? slot_ff[free_idx].key : '0;
         rsp.buffer_id   = BUF_ID_W'(buf_ff[free_idx]);
         for (int n = 0; n < ENTRIES; n++) begin
            if (n == 0) begin
               slot_in[n] = new_slot;
               buf_in[n]  = buf_ff[free_idx];
            end else if (IW'(n) <= free_idx) begin
               slot_in[n] = slot_ff[(n + ENTRIES - 1) % ENTRIES];
               buf_in[n]  = buf_ff[(n + ENTRIES - 1) % ENTRIES];
            end
         end
      end

      if (rm_en) begin
         for (int n = 0; n < ENTRIES; n++) begin
            if (IW'(n) >= rm_idx) begin
               if (n == ENTRIES - 1) begin
                  slot_in[n]       = slot_ff[rm_idx];
                  slot_in[n].valid = 1'b0;
                  buf_in[n]        = buf_ff[rm_idx];
               end else begin
                  slot_in[n] = slot_ff[(n + 1) % ENTRIES];
                  buf_in[n]  = buf_ff[(n + 1) % ENTRIES];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < ENTRIES; n++) begin
            slot_ff[n].valid <= 1'b0;
            buf_ff[n]        <= IW'(n);
         end
      end else if (fire) begin
         slot_ff <= slot_in;
         buf_ff  <= buf_in;
      end
   end

endmodule
